// ===== design/message_fragmenter_with_header_macros.svh =====
// Assertion macros for the message fragmenter block.
// Used by the top level; expects clk and rst in scope.
`ifndef MESSAGE_FRAGMENTER_WITH_HEADER_MACROS_SVH
`define MESSAGE_FRAGMENTER_WITH_HEADER_MACROS_SVH

`define MFWH_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define MFWH_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MFWH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mfwh_pkg.sv =====
// Shared constants and the command type for the message fragmenter.
// No dependencies.
package mfwh_pkg;

  localparam logic [15:0] MAX_MESSAGE_LEN = 16'd4096;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic [15:0] PAYLOAD_RESET = 16'd20;
  localparam logic [15:0] HDR_LEN       = 16'd10;
  localparam logic [3:0]  HDR_BYTES     = 4'd10;

  localparam logic [7:0] MAGIC0  = 8'hAA;
  localparam logic [7:0] MAGIC1  = 8'h55;
  localparam logic [7:0] MAGIC2  = 8'hC3;
  localparam logic [7:0] VERSION = 8'h01;

  localparam logic [1:0] KIND_PACKET    = 2'd0;
  localparam logic [1:0] KIND_TOO_LONG  = 2'd1;
  localparam logic [1:0] KIND_TOO_SMALL = 2'd2;

  typedef struct packed {
    logic        hdr;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic        done;
    logic [1:0]  kind;
    logic [15:0] pnum;
    logic [15:0] pcount;
    logic [15:0] len;
  } cmd_t;

endpackage

// ===== design/mfwh_if.sv =====
// Valid/ready channel interfaces for the input items and the result bytes.
// No dependencies.
interface mfwh_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  data_byte;
  logic [15:0] message_length;
  logic [15:0] write_length;

  modport source (output valid, action, data_byte, message_length, write_length,
                  input ready);
  modport sink (input valid, action, data_byte, message_length, write_length,
                output ready);
endinterface

interface mfwh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_first;
  logic       packet_last;
  logic       message_done;
  logic [1:0] kind;

  modport source (output valid, out_byte, packet_first, packet_last, message_done, kind,
                  input ready);
  modport sink (input valid, out_byte, packet_first, packet_last, message_done, kind,
                output ready);
endinterface

// ===== design/message_fragmenter_with_header.sv =====
// Message fragmenter with sequence header. Each message byte gives one result byte
// when the message fits the tracked payload size; otherwise, if payload_size > 10 and
// the message is at most MAX_MESSAGE_LEN, every chunk of payload_size - 10 bytes is
// preceded by a 10-byte header (AA 55 C3 01, packet index, packet count, length,
// big-endian). The result side runs at one byte per cycle while result.ready holds;
// the input stalls on each header once the command queue (QUEUE_DEPTH entries) fills.
// A fragmented message's first byte holds the input while a bit-serial divider works
// out the packet count. Size reports and dropped bytes give no result.
`include "message_fragmenter_with_header_macros.svh"

module message_fragmenter_with_header #(
  parameter int unsigned QUEUE_DEPTH = mfwh_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  mfwh_in_if.sink    item,
  mfwh_out_if.source result
);

  logic           push, full, pop, pop_valid;
  mfwh_pkg::cmd_t push_cmd, pop_cmd;
  logic           div_start, div_done;
  logic [16:0]    div_num;
  logic [15:0]    div_den, div_quot;

  mfwh_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  mfwh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quot  (div_quot)
  );

  mfwh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid)
  );

  mfwh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .result    (result)
  );

  `MFWH_ASSERT(a_no_push_when_full, !(push && full), "command pushed into a full queue")
  `MFWH_ASSERT(a_pop_needs_entry, !pop || pop_valid, "command popped from an empty queue")
  `MFWH_ASSERT_NEXT(a_div_restart, div_start, !div_done, "divider done right after start")
  `MFWH_ASSERT_IMPL(a_reject_shape, result.valid && (result.kind != mfwh_pkg::KIND_PACKET), result.message_done && !result.packet_first && !result.packet_last, "malformed reject result")

endmodule

// ===== design/mfwh_div.sv =====
// Restoring divider, one quotient bit per cycle, for the packet count.
// Depends on nothing.
module mfwh_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quot
);

  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [16:0] q;
  logic [15:0] den_r;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem, q[16]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  assign quot = q[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= '0;
      rem   <= '0;
      q     <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[15:0] : trial[15:0];
      q   <= {q[15:0], ge};
      cnt <= cnt + 5'd1;
      if (cnt == 5'd16) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== design/mfwh_front.sv =====
// Front end: takes items, tracks message state and queues payload and reject commands.
// Depends on mfwh_pkg, mfwh_if and the divider at the top level.
module mfwh_front (
  input  logic               clk,
  input  logic               rst,
  mfwh_in_if.sink            item,
  output logic               push,
  output mfwh_pkg::cmd_t     push_cmd,
  input  logic               full,
  output logic               div_start,
  output logic [16:0]        div_num,
  output logic [15:0]        div_den,
  input  logic               div_done,
  input  logic [15:0]        div_quot
);

  typedef enum logic [1:0] {MODE_DIRECT, MODE_FRAG, MODE_DROP} mode_t;
  typedef enum logic {ST_ACCEPT, ST_DIVIDE} state_t;

  state_t      state;
  mode_t       message_mode;
  logic [15:0] payload_size;
  logic        in_message;
  logic [15:0] bytes_seen;
  logic [15:0] chunk_size;
  logic [15:0] chunk_position;
  logic [15:0] packet_number;
  logic [15:0] packet_count;
  logic [7:0]  held_byte;
  logic [15:0] held_len;

  logic        take, is_msg, opening, too_long, fits, too_small, start_frag;
  logic        finish, proc, reject, size_up;
  logic [1:0]  reject_kind;
  mode_t       e_mode;
  logic [15:0] e_bs, e_cp, e_pn, e_pc, e_cs, e_len;
  logic [7:0]  e_b;
  logic [15:0] bs_next, cp_next;
  logic        msg_end, chunk_end;

  assign item.ready = (state == ST_ACCEPT) && !full;

  always_comb begin
    take       = item.valid && item.ready;
    is_msg     = take && !item.action;
    opening    = is_msg && !in_message && (item.message_length != 16'd0);
    too_long   = item.message_length > mfwh_pkg::MAX_MESSAGE_LEN;
    fits       = item.message_length <= payload_size;
    too_small  = payload_size <= mfwh_pkg::HDR_LEN;
    start_frag = opening && !too_long && !fits && !too_small;
    reject     = opening && (too_long || (!fits && too_small));
    reject_kind = too_long ? mfwh_pkg::KIND_TOO_LONG : mfwh_pkg::KIND_TOO_SMALL;
    size_up    = take && item.action && (item.write_length > payload_size) &&
                 (item.write_length <= mfwh_pkg::MAX_MESSAGE_LEN);

    div_start = start_frag;
    div_den   = payload_size - mfwh_pkg::HDR_LEN;
    div_num   = {1'b0, item.message_length} + {1'b0, div_den} - 17'd1;

    finish = (state == ST_DIVIDE) && div_done && !full;
    proc   = finish || (is_msg && (in_message || (item.message_length != 16'd0)) &&
                        !start_frag);

    e_mode = message_mode;
    e_bs   = bytes_seen;
    e_cp   = chunk_position;
    e_pn   = packet_number;
    e_pc   = packet_count;
    e_cs   = chunk_size;
    e_b    = item.data_byte;
    e_len  = item.message_length;
    if (finish) begin
      e_mode = MODE_FRAG;
      e_bs   = '0;
      e_cp   = '0;
      e_pn   = '0;
      e_pc   = div_quot;
      e_b    = held_byte;
      e_len  = held_len;
    end else if (opening) begin
      e_bs = '0;
      e_cp = '0;
      e_pn = '0;
      if (too_long || !fits) begin
        e_mode = MODE_DROP;
      end else begin
        e_mode = MODE_DIRECT;
        e_cs   = '0;
        e_pc   = 16'd1;
      end
    end

    bs_next   = e_bs + 16'd1;
    msg_end   = bs_next >= e_len;
    cp_next   = e_cp + 16'd1;
    chunk_end = msg_end || (cp_next >= e_cs);

    push = reject || (proc && (e_mode != MODE_DROP));

    push_cmd.hdr    = 1'b0;
    push_cmd.data   = e_b;
    push_cmd.first  = 1'b0;
    push_cmd.last   = msg_end;
    push_cmd.done   = msg_end;
    push_cmd.kind   = mfwh_pkg::KIND_PACKET;
    push_cmd.pnum   = e_pn;
    push_cmd.pcount = e_pc;
    push_cmd.len    = e_len;
    if (reject) begin
      push_cmd.data  = '0;
      push_cmd.last  = 1'b0;
      push_cmd.done  = 1'b1;
      push_cmd.kind  = reject_kind;
    end else if (e_mode == MODE_DIRECT) begin
      push_cmd.first = bs_next == 16'd1;
    end else begin
      push_cmd.hdr  = e_cp == 16'd0;
      push_cmd.last = chunk_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_ACCEPT;
      message_mode   <= MODE_DIRECT;
      payload_size   <= mfwh_pkg::PAYLOAD_RESET;
      in_message     <= 1'b0;
      bytes_seen     <= '0;
      chunk_size     <= '0;
      chunk_position <= '0;
      packet_number  <= '0;
      packet_count   <= '0;
    end else begin
      if (size_up) begin
        payload_size <= item.write_length;
      end
      if (start_frag) begin
        state      <= ST_DIVIDE;
        held_byte  <= item.data_byte;
        held_len   <= item.message_length;
        chunk_size <= div_den;
      end
      if (finish) begin
        state <= ST_ACCEPT;
      end
      if (proc) begin
        message_mode <= e_mode;
        bytes_seen   <= bs_next;
        chunk_size   <= e_cs;
        packet_count <= e_pc;
        in_message   <= !msg_end;
        if (e_mode == MODE_FRAG) begin
          chunk_position <= chunk_end ? 16'd0 : cp_next;
          packet_number  <= chunk_end ? e_pn + 16'd1 : e_pn;
        end else begin
          chunk_position <= e_cp;
          packet_number  <= e_pn;
        end
      end
    end
  end

endmodule

// ===== design/mfwh_fifo.sv =====
// Command queue between the front end and the byte emitter.
// Depends on mfwh_pkg.
module mfwh_fifo #(
  parameter int unsigned DEPTH = mfwh_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mfwh_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output mfwh_pkg::cmd_t pop_cmd,
  output logic           pop_valid
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mfwh_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = count == CW'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== design/mfwh_back.sv =====
// Back end: expands queued commands into header and payload bytes on the result channel.
// Depends on mfwh_pkg and mfwh_if.
module mfwh_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  input  mfwh_pkg::cmd_t pop_cmd,
  output logic           pop,
  mfwh_out_if.source     result
);

  mfwh_pkg::cmd_t cur;
  logic           cur_valid;
  logic [3:0]     idx;

  logic           emit_hdr, advance, step;
  logic [7:0]     nb;
  logic           nf, nl, nd;
  logic [1:0]     nk;

  always_comb begin
    emit_hdr = cur.hdr && (idx < mfwh_pkg::HDR_BYTES);
    nb = cur.data;
    nf = cur.first;
    nl = cur.last;
    nd = cur.done;
    nk = cur.kind;
    if (emit_hdr) begin
      nf = idx == 4'd0;
      nl = 1'b0;
      nd = 1'b0;
      nk = mfwh_pkg::KIND_PACKET;
      case (idx)
        4'd0:    nb = mfwh_pkg::MAGIC0;
        4'd1:    nb = mfwh_pkg::MAGIC1;
        4'd2:    nb = mfwh_pkg::MAGIC2;
        4'd3:    nb = mfwh_pkg::VERSION;
        4'd4:    nb = cur.pnum[15:8];
        4'd5:    nb = cur.pnum[7:0];
        4'd6:    nb = cur.pcount[15:8];
        4'd7:    nb = cur.pcount[7:0];
        4'd8:    nb = cur.len[15:8];
        4'd9:    nb = cur.len[7:0];
        default: nb = cur.data;
      endcase
    end
    advance = !result.valid || result.ready;
    step    = advance && cur_valid;
    pop     = pop_valid && (!cur_valid || (step && !emit_hdr));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      idx          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (advance) begin
        result.valid <= cur_valid;
      end
      if (step) begin
        result.out_byte     <= nb;
        result.packet_first <= nf;
        result.packet_last  <= nl;
        result.message_done <= nd;
        result.kind         <= nk;
        idx <= emit_hdr ? idx + 4'd1 : 4'd0;
      end
      if (pop) begin
        cur       <= pop_cmd;
        cur_valid <= 1'b1;
      end else if (step && !emit_hdr) begin
        cur_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/fragment_checker.sv =====
// Scoreboard for the message fragmenter: predicts the result bytes of every
// accepted input transfer and compares them with the result channel.
// Depends on mfwh_pkg and the channel interfaces in mfwh_if.sv.
module fragment_checker (
  input  logic clk,
  input  logic rst,
  mfwh_in_if   in_ch,
  mfwh_out_if  out_ch,
  output int   errors,
  output int   pending
);

  typedef enum logic [1:0] {MODE_PASS, MODE_SPLIT, MODE_DISCARD} msg_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       done;
    logic [1:0] kind;
  } frag_result_t;

  frag_result_t expected_bytes[$];
  frag_result_t got, want;

  logic [15:0] link_payload;
  logic [15:0] seen_count;
  logic [15:0] chunk_span;
  logic [15:0] chunk_pos;
  logic [15:0] pkt_index;
  logic [15:0] pkt_total;
  logic        msg_open;
  msg_mode_t   msg_mode;

  function automatic void push_expected(logic [7:0] d, logic f, logic l, logic dn,
                                        logic [1:0] k);
    frag_result_t entry;
    entry = {d, f, l, dn, k};
    expected_bytes.insert(expected_bytes.size(), entry);
  endfunction

  task automatic predict_item(input logic act, input logic [7:0] b,
                              input logic [15:0] len, input logic [15:0] wlen);
    logic        live;
    logic        msg_end;
    logic        chunk_end;
    logic [31:0] ceil_count;
    live = 1'b1;
    if (act) begin
      if (wlen > link_payload && wlen <= mfwh_pkg::MAX_MESSAGE_LEN) link_payload = wlen;
      live = 1'b0;
    end else if (!msg_open) begin
      if (len == 16'd0) begin
        live = 1'b0;
      end else begin
        msg_open   = 1'b1;
        seen_count = 16'd0;
        chunk_pos  = 16'd0;
        pkt_index  = 16'd0;
        if (len > mfwh_pkg::MAX_MESSAGE_LEN) begin
          msg_mode = MODE_DISCARD;
          push_expected(8'h00, 1'b0, 1'b0, 1'b1, mfwh_pkg::KIND_TOO_LONG);
        end else if (len <= link_payload) begin
          msg_mode   = MODE_PASS;
          chunk_span = 16'd0;
          pkt_total  = 16'd1;
        end else if (link_payload <= mfwh_pkg::HDR_LEN) begin
          msg_mode = MODE_DISCARD;
          push_expected(8'h00, 1'b0, 1'b0, 1'b1, mfwh_pkg::KIND_TOO_SMALL);
        end else begin
          msg_mode   = MODE_SPLIT;
          chunk_span = link_payload - mfwh_pkg::HDR_LEN;
          ceil_count = ({16'd0, len} + {16'd0, chunk_span} - 32'd1) / {16'd0, chunk_span};
          pkt_total  = ceil_count[15:0];
        end
      end
    end
    if (live) begin
      seen_count = seen_count + 16'd1;
      msg_end = (seen_count >= len);
      case (msg_mode)
        MODE_PASS: begin
          push_expected(b, seen_count == 16'd1, msg_end, msg_end, mfwh_pkg::KIND_PACKET);
        end
        MODE_SPLIT: begin
          if (chunk_pos == 16'd0) begin
            push_expected(mfwh_pkg::MAGIC0, 1'b1, 1'b0, 1'b0, mfwh_pkg::KIND_PACKET);
            push_expected(mfwh_pkg::MAGIC1, 1'b0, 1'b0, 1'b0, mfwh_pkg::KIND_PACKET);
            push_expected(mfwh_pkg::MAGIC2, 1'b0, 1'b0, 1'b0, mfwh_pkg::KIND_PACKET);
            push_expected(mfwh_pkg::VERSION, 1'b0, 1'b0, 1'b0, mfwh_pkg::KIND_PACKET);
            push_expected(pkt_index[15:8], 1'b0, 1'b0, 1'b0, mfwh_pkg::KIND_PACKET);
            push_expected(pkt_index[7:0], 1'b0, 1'b0, 1'b0, mfwh_pkg::KIND_PACKET);
            push_expected(pkt_total[15:8], 1'b0, 1'b0, 1'b0, mfwh_pkg::KIND_PACKET);
            push_expected(pkt_total[7:0], 1'b0, 1'b0, 1'b0, mfwh_pkg::KIND_PACKET);
            push_expected(len[15:8], 1'b0, 1'b0, 1'b0, mfwh_pkg::KIND_PACKET);
            push_expected(len[7:0], 1'b0, 1'b0, 1'b0, mfwh_pkg::KIND_PACKET);
          end
          chunk_pos = chunk_pos + 16'd1;
          chunk_end = msg_end || (chunk_pos >= chunk_span);
          push_expected(b, 1'b0, chunk_end, msg_end, mfwh_pkg::KIND_PACKET);
          if (chunk_end) begin
            chunk_pos = 16'd0;
            pkt_index = pkt_index + 16'd1;
          end
        end
        default: begin
        end
      endcase
      if (msg_end) msg_open = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      link_payload = mfwh_pkg::PAYLOAD_RESET;
      msg_open     = 1'b0;
      msg_mode     = MODE_PASS;
      seen_count   = 16'd0;
      chunk_span   = 16'd0;
      chunk_pos    = 16'd0;
      pkt_index    = 16'd0;
      pkt_total    = 16'd0;
      expected_bytes.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_item(in_ch.action, in_ch.data_byte, in_ch.message_length,
                     in_ch.write_length);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_byte, out_ch.packet_first, out_ch.packet_last,
               out_ch.message_done, out_ch.kind};
        if (expected_bytes.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) begin
            $display("unexpected result: byte %h first %b last %b done %b kind %0d",
                     got.data, got.first, got.last, got.done, got.kind);
          end
        end else begin
          want = expected_bytes.pop_front();
          if (got.data !== want.data || got.first !== want.first ||
              got.last !== want.last || got.done !== want.done ||
              got.kind !== want.kind) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("mismatch: expected byte %h first %b last %b done %b kind %0d",
                       want.data, want.first, want.last, want.done, want.kind);
              $display("          got      byte %h first %b last %b done %b kind %0d",
                       got.data, got.first, got.last, got.done, got.kind);
            end
          end
        end
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the message fragmenter testbench: clock, reset, input transfers and
// result-side backpressure, with fragment_checker beside the block for scoring.
// Depends on mfwh_pkg, mfwh_if.sv, fragment_checker and the block itself.
module testbench;

  localparam int IDLE_LIMIT  = 4000;
  localparam int ITEM_TARGET = 200;
  localparam int QUIET_FROM  = 165;
  localparam int DRAIN_WAIT  = 40;

  logic clk = 1'b0;
  logic rst;

  mfwh_in_if  item_ch ();
  mfwh_out_if result_ch ();

  int errors;
  int pending;
  int idle_cycles;
  int items_sent;
  int link_size;
  bit quiet;

  message_fragmenter_with_header DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  fragment_checker frag_check (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (item_ch),
    .out_ch  (result_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      if (!quiet) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b, input logic [15:0] mlen,
                           input logic [15:0] wlen);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.action         <= act;
    item_ch.data_byte      <= b;
    item_ch.message_length <= mlen;
    item_ch.write_length   <= wlen;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_report(input logic [15:0] w);
    send_item(1'b1, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), w);
    if (w > link_size && w <= mfwh_pkg::MAX_MESSAGE_LEN) link_size = w;
  endtask

  // first byte carries first_len; if first_len > 1, bytes carrying rest_len follow
  task automatic send_message(input logic [15:0] first_len, input logic [15:0] rest_len);
    int k;
    send_item(1'b0, 8'($urandom_range(0, 255)), first_len, 16'($urandom_range(0, 65535)));
    k = 1;
    if (first_len > 16'd1) begin
      do begin
        send_item(1'b0, 8'($urandom_range(0, 255)), rest_len,
                  16'($urandom_range(0, 65535)));
        k++;
      end while (k < rest_len);
    end
  endtask

  initial begin
    int pick;
    int len;
    int extra;
    int cap;
    rst                    = 1'b1;
    quiet                  = 1'b0;
    items_sent             = 0;
    link_size              = mfwh_pkg::PAYLOAD_RESET;
    item_ch.valid          = 1'b0;
    item_ch.action         = 1'b0;
    item_ch.data_byte      = 8'h00;
    item_ch.message_length = 16'd0;
    item_ch.write_length   = 16'd0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(1'b0, 8'hFF, 16'd0, 16'hFFFF);
    send_message(16'd1, 16'd1);
    send_message(16'd2, 16'd2);
    send_report(16'd0);
    send_report(16'hFFFF);
    send_report(16'd4097);
    send_message(16'd4096, 16'd2);
    send_message(16'hFFFF, 16'd2);
    send_message(16'd4097, 16'd1);
    send_message(16'd30, 16'd0);
    send_message(16'd21, 16'd21);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        case ($urandom_range(0, 3))
          0, 1:    send_report(16'(link_size + $urandom_range(1, 6)));
          2:       send_report(16'($urandom_range(4097, 65535)));
          default: send_report(16'($urandom_range(0, link_size)));
        endcase
      end else if (pick < 45) begin
        cap = (link_size < 40) ? link_size : 40;
        len = $urandom_range(1, cap);
        send_message(16'(len), 16'(len));
      end else if (pick < 88) begin
        extra = (link_size - 10) * 2;
        if (extra > 30) extra = 30;
        len = $urandom_range(link_size + 1, link_size + extra);
        if ($urandom_range(0, 6) == 0) begin
          send_message(16'(len), 16'($urandom_range(1, len + 5)));
        end else begin
          send_message(16'(len), 16'(len));
        end
      end else if (pick < 94) begin
        send_message(16'($urandom_range(4097, 65535)), 16'($urandom_range(1, 4)));
      end else if (pick < 97) begin
        send_item(1'b0, 8'($urandom_range(0, 255)), 16'd0, 16'($urandom_range(0, 65535)));
      end else begin
        send_message(16'($urandom_range(link_size + 1, 4096)), 16'($urandom_range(1, 15)));
      end
    end

    send_report(16'd4096);
    send_message(16'd4096, 16'd3);
    send_message(16'd4097, 16'd2);
    send_message(16'd5, 16'd5);

    item_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
